[design/ilst_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the indexed ordered list.
// No dependencies; every other design file imports this package.
package ilst_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 7;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// compare width wide enough for both a request index and a cell index
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int REQ_W    = 3;
	localparam int OUT_CNT_W = 7;

	localparam logic [REQ_W-1:0] REQ_GET       = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_INS_AT    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DEL_AT    = 3'd4;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} cell_op_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t          op;
		logic [CMP_W-1:0]  pos;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

	// request outcome from the controller to the output stage
	typedef struct packed {
		status_t          status;
		logic             get_ok;
		logic             get_bad;
		logic [CNT_W-1:0] count_after;
	} ctrl_res_t;

endpackage

[design/indexed_ordered_list.sv]
`timescale 1ns / 1ps
// Top level of the indexed ordered list: controller, cell chain, output register.
// Depends on ilst_pkg, ilst_ctrl and ilst_cell.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tuser: req_type; tdata: position, item_value
//  m_*       out  m_tvalid/m_tready   tuser: status; tdata: read_value, entry_count
//
// One item per cycle unless stalled: every request finishes in the cycle it is
// accepted, the whole cell chain shifting at once; the result appears in the
// next cycle. The output register is the only stage; s_tready is high while
// it is empty or being drained. Reset clears the count and the output valid;
// cell contents stay undefined until written and are never read unwritten.
module indexed_ordered_list
	import ilst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [6:0] position, [38:7] item_value, [39] zero
	input  logic [2:0]  s_tuser,   // [2:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] read_value, [38:32] entry_count, [39] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	logic              accept;
	cell_cmd_t         cmd;
	ctrl_res_t         res;
	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] cell_rd   [CAPACITY];
	logic [DATA_W-1:0] rd_sel;
	logic [DATA_W-1:0] read_value;

	logic                 m_tvalid_q;
	logic [DATA_W-1:0]    read_value_q;
	logic [OUT_CNT_W-1:0] entry_count_q;
	status_t              status_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	ilst_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (s_tuser),
		.position   (s_tdata[POS_W-1:0]),
		.item_value (s_tdata[POS_W+DATA_W-1:POS_W]),
		.cmd        (cmd),
		.res        (res)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		if (i == 0) begin : g_first
			assign lo = cmd.value;
		end else begin : g_mid_lo
			assign lo = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign hi = '0;
		end else begin : g_mid_hi
			assign hi = cell_data[i+1];
		end
		ilst_cell u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.idx     (CMP_W'(i)),
			.lo_data (lo),
			.hi_data (hi),
			.data    (cell_data[i]),
			.rd_data (cell_rd[i])
		);
	end

	// at most one cell matches the index, so OR picks its entry
	always_comb begin
		rd_sel = '0;
		for (int i = 0; i < CAPACITY; i++)
			rd_sel = rd_sel | cell_rd[i];
	end

	always_comb begin
		if (res.get_ok)
			read_value = rd_sel;
		else if (res.get_bad)
			read_value = '1;
		else
			read_value = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (accept)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q  <= read_value;
			entry_count_q <= OUT_CNT_W'(res.count_after);
			status_q      <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, entry_count_q, read_value_q};
	assign m_tuser  = status_q;

endmodule

[design/ilst_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one entry, shifts with neighbors.
// Depends on ilst_pkg.
module ilst_cell
	import ilst_pkg::*;
(
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [CMP_W-1:0]  idx,
	input  logic [DATA_W-1:0] lo_data,
	input  logic [DATA_W-1:0] hi_data,
	output logic [DATA_W-1:0] data,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] data_q;
	logic              hit;
	logic              above;

	assign hit   = (idx == cmd.pos);
	assign above = (idx > cmd.pos);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INSERT: begin
				if (hit)
					data_q <= cmd.value;
				else if (above)
					data_q <= lo_data;
			end
			OP_DELETE: begin
				if (hit || above)
					data_q <= hi_data;
			end
			default: begin
			end
		endcase
	end

	assign data    = data_q;
	assign rd_data = hit ? data_q : '0;

endmodule

[design/ilst_ctrl.sv]
`timescale 1ns / 1ps
// Request decode, range/full checks and the entry count register.
// Depends on ilst_pkg.
module ilst_ctrl
	import ilst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [POS_W-1:0]  position,
	input  logic [DATA_W-1:0] item_value,
	output cell_cmd_t         cmd,
	output ctrl_res_t         res
);

	logic [CNT_W-1:0] count_q;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] pos_ext;
	logic             full;
	cell_op_t         op;
	logic [CMP_W-1:0] op_pos;

	assign cnt_ext = CMP_W'(count_q);
	assign pos_ext = CMP_W'(position);
	assign full    = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		op          = OP_HOLD;
		op_pos      = pos_ext;
		res.status  = ST_OK;
		res.get_ok  = 1'b0;
		res.get_bad = 1'b0;
		case (req_type)
			REQ_GET: begin
				if (pos_ext >= cnt_ext) begin
					res.status  = ST_RANGE;
					res.get_bad = 1'b1;
				end else begin
					res.get_ok = 1'b1;
				end
			end
			REQ_INS_FRONT: begin
				op_pos = '0;
				if (full)
					res.status = ST_FULL;
				else
					op = OP_INSERT;
			end
			REQ_INS_BACK: begin
				op_pos = cnt_ext;
				if (full)
					res.status = ST_FULL;
				else
					op = OP_INSERT;
			end
			REQ_INS_AT: begin
				if (pos_ext > cnt_ext)
					res.status = ST_RANGE;
				else if (full)
					res.status = ST_FULL;
				else
					op = OP_INSERT;
			end
			REQ_DEL_AT: begin
				if (pos_ext >= cnt_ext)
					res.status = ST_RANGE;
				else
					op = OP_DELETE;
			end
			default: begin
			end
		endcase

		case (op)
			OP_INSERT: res.count_after = count_q + CNT_W'(1);
			OP_DELETE: res.count_after = count_q - CNT_W'(1);
			default:   res.count_after = count_q;
		endcase

		cmd.op    = accept ? op : OP_HOLD;
		cmd.pos   = op_pos;
		cmd.value = item_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (accept)
			count_q <= res.count_after;
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for indexed_ordered_list: directed table, fill to capacity,
// then random grow/shrink traffic checked against a queue-based list predictor.
// Depends on ilst_pkg and the indexed_ordered_list RTL.
module tb_top;
	import ilst_pkg::*;

	// request codes the block has no operation for
	localparam logic [REQ_W-1:0] REQ_RSV_A = 3'd5;
	localparam logic [REQ_W-1:0] REQ_RSV_B = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSV_C = 3'd7;
	localparam logic [DATA_W-1:0] NEG_ONE = 32'hFFFF_FFFF;
	localparam logic [6:0] FULL_CNT = 7'(CAPACITY);
	localparam int N_OPEN = 19;
	localparam int N_AT_FULL = 11;
	localparam int RAND_PER_PHASE = 120;
	localparam int MAX_PRINTS = 40;

	typedef struct packed {
		logic [DATA_W-1:0] rd;
		status_t           st;
		logic [6:0]        cnt;
	} list_result_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		logic              typed;   // exp holds a hand-written result
		list_result_t      exp;
	} stim_row_t;

	localparam list_result_t NO_TYPED = '{32'd0, ST_OK, 7'd0};

	// list of length zero at the start, special cases first
	localparam stim_row_t OPEN_ROWS [0:N_OPEN-1] = '{
		'{REQ_GET,       7'd0,   32'd0,         1'b1, '{NEG_ONE, ST_RANGE, 7'd0}},
		'{REQ_DEL_AT,    7'd0,   32'd0,         1'b1, '{32'd0,   ST_RANGE, 7'd0}},
		'{REQ_INS_AT,    7'd1,   32'h1234_5678, 1'b1, '{32'd0,   ST_RANGE, 7'd0}},
		'{REQ_GET,       7'd127, 32'd0,         1'b1, '{NEG_ONE, ST_RANGE, 7'd0}},
		'{REQ_RSV_A,     7'd127, NEG_ONE,       1'b1, '{32'd0,   ST_OK,    7'd0}},
		'{REQ_INS_AT,    7'd0,   32'h7FFF_FFFF, 1'b1, '{32'd0,   ST_OK,    7'd1}},
		'{REQ_INS_FRONT, 7'd0,   32'h8000_0000, 1'b1, '{32'd0,   ST_OK,    7'd2}},
		'{REQ_INS_BACK,  7'd127, NEG_ONE,       1'b1, '{32'd0,   ST_OK,    7'd3}},
		'{REQ_INS_AT,    7'd3,   32'd0,         1'b1, '{32'd0,   ST_OK,    7'd4}},
		'{REQ_INS_AT,    7'd2,   32'h5A5A_5A5A, 1'b1, '{32'd0,   ST_OK,    7'd5}},
		'{REQ_GET,       7'd0,   NEG_ONE,       1'b0, NO_TYPED},
		'{REQ_GET,       7'd4,   32'd0,         1'b0, NO_TYPED},
		'{REQ_GET,       7'd5,   32'd0,         1'b1, '{NEG_ONE, ST_RANGE, 7'd5}},
		'{REQ_DEL_AT,    7'd5,   32'd0,         1'b1, '{32'd0,   ST_RANGE, 7'd5}},
		'{REQ_DEL_AT,    7'd2,   32'd0,         1'b1, '{32'd0,   ST_OK,    7'd4}},
		'{REQ_RSV_B,     7'd0,   32'h8000_0000, 1'b1, '{32'd0,   ST_OK,    7'd4}},
		'{REQ_RSV_C,     7'd127, 32'h7FFF_FFFF, 1'b1, '{32'd0,   ST_OK,    7'd4}},
		'{REQ_INS_AT,    7'd6,   32'hA5A5_A5A5, 1'b1, '{32'd0,   ST_RANGE, 7'd4}},
		'{REQ_GET,       7'd2,   32'd0,         1'b0, NO_TYPED}
	};

	// run against a full list
	localparam stim_row_t FULL_ROWS [0:N_AT_FULL-1] = '{
		'{REQ_GET,       7'd0,            32'd0,   1'b0, NO_TYPED},
		'{REQ_GET,       FULL_CNT - 7'd1, 32'd0,   1'b0, NO_TYPED},
		'{REQ_GET,       FULL_CNT,        32'd0,   1'b1, '{NEG_ONE, ST_RANGE, FULL_CNT}},
		'{REQ_INS_FRONT, 7'd0,            NEG_ONE, 1'b1, '{32'd0,   ST_FULL,  FULL_CNT}},
		'{REQ_INS_BACK,  7'd0,            32'd1,   1'b1, '{32'd0,   ST_FULL,  FULL_CNT}},
		'{REQ_INS_AT,    FULL_CNT,        32'd2,   1'b1, '{32'd0,   ST_FULL,  FULL_CNT}},
		// a bad index wins over the full flag
		'{REQ_INS_AT,    FULL_CNT + 7'd1, 32'd3,   1'b1, '{32'd0,   ST_RANGE, FULL_CNT}},
		'{REQ_DEL_AT,    7'd127,          32'd0,   1'b1, '{32'd0,   ST_RANGE, FULL_CNT}},
		'{REQ_DEL_AT,    7'd0,            32'd0,   1'b1, '{32'd0,   ST_OK,    FULL_CNT - 7'd1}},
		'{REQ_DEL_AT,    FULL_CNT - 7'd2, 32'd0,   1'b0, NO_TYPED},
		'{REQ_INS_AT,    7'd0,            32'hC3C3_3C3C, 1'b0, NO_TYPED}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // [6:0] position, [38:7] item_value, [39] zero
	logic [2:0]  s_tuser = '0;   // [2:0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [31:0] read_value, [38:32] entry_count, [39] zero
	logic [1:0]  m_tuser;        // [1:0] status

	// travel with the item on s_*, read at the accepting edge
	logic         row_typed = 1'b0;
	list_result_t row_exp = NO_TYPED;

	logic [DATA_W-1:0] shadow_list [$];
	list_result_t      due_results [$];
	int                mismatches = 0;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;

	indexed_ordered_list DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
	end

	// Applies one request to the shadow list, returns the result it gives.
	function automatic list_result_t apply_request(logic [REQ_W-1:0] req,
			logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
		list_result_t r;
		int n;
		n = shadow_list.size();
		r = NO_TYPED;
		case (req)
			REQ_GET: begin
				if (pos < n) begin
					r.rd = shadow_list[pos];
				end else begin
					r.rd = NEG_ONE;
					r.st = ST_RANGE;
				end
			end
			REQ_INS_FRONT: begin
				if (n >= CAPACITY) r.st = ST_FULL;
				else shadow_list.push_front(val);
			end
			REQ_INS_BACK: begin
				if (n >= CAPACITY) r.st = ST_FULL;
				else shadow_list.push_back(val);
			end
			REQ_INS_AT: begin
				if (pos > n) r.st = ST_RANGE;
				else if (n >= CAPACITY) r.st = ST_FULL;
				else shadow_list.insert(int'(pos), val);
			end
			REQ_DEL_AT: begin
				if (pos >= n) r.st = ST_RANGE;
				else shadow_list.delete(int'(pos));
			end
			default: ;
		endcase
		r.cnt = 7'(shadow_list.size());
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < MAX_PRINTS)
			$display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
		mismatches++;
	endtask

	// Output check first: a result never belongs to the item accepted at the same edge.
	always @(posedge clk) begin : scoreboard
		list_result_t want;
		list_result_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					report_mismatch("unrequested result", m_tdata[31:0], 32'd0);
				end else begin
					want = due_results.pop_front();
					if (m_tdata[31:0] !== want.rd)
						report_mismatch("read_value", m_tdata[31:0], want.rd);
					if (m_tuser !== want.st)
						report_mismatch("status", 32'(m_tuser), 32'(want.st));
					if (m_tdata[38:32] !== want.cnt)
						report_mismatch("entry_count", 32'(m_tdata[38:32]), 32'(want.cnt));
				end
			end
			if (s_tvalid && s_tready) begin
				got = apply_request(s_tuser, s_tdata[6:0], s_tdata[38:7]);
				due_results.push_back(row_typed ? row_exp : got);
			end
		end
	end

	task automatic send_item(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
			logic [DATA_W-1:0] val, logic typed, list_result_t exp);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tuser   <= req;
		s_tdata   <= {1'b0, val, pos};
		row_typed <= typed;
		row_exp   <= exp;
		do @(posedge clk); while (!s_tready);
	endtask

	// Hold the sender off until every outstanding result is back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
	endtask

	// Grow phases favor inserts until the list is full, shrink phases favor
	// deletes until it is empty; a few items are noise with any code and index.
	task automatic send_random(int n_items);
		int i;
		int n_now;
		int pick;
		bit growing;
		logic [REQ_W-1:0]  req;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		growing = (shadow_list.size() < CAPACITY / 2);
		for (i = 0; i < n_items; i++) begin
			n_now = shadow_list.size();
			if (n_now >= CAPACITY && $urandom_range(3, 0) == 0) growing = 1'b0;
			else if (n_now == 0) growing = 1'b1;
			pick = $urandom_range(99, 0);
			val = $urandom();
			if (pick < 8) begin
				req = REQ_W'($urandom_range(REQ_RSV_C, REQ_GET));
				pos = POS_W'($urandom_range(127, 0));
			end else if (pick < 28) begin
				req = REQ_GET;
				pos = POS_W'($urandom_range(n_now, 0));
			end else if (pick < (growing ? 90 : 45)) begin
				case ($urandom_range(2, 0))
					0: req = REQ_INS_FRONT;
					1: req = REQ_INS_BACK;
					default: req = REQ_INS_AT;
				endcase
				pos = POS_W'($urandom_range(n_now + 1, 0));
			end else begin
				req = REQ_DEL_AT;
				pos = POS_W'($urandom_range(n_now, 0));
			end
			send_item(req, pos, val, 1'b0, NO_TYPED);
		end
	endtask

	initial begin : stimulus
		int i;
		int fill;
		send_idle_pct = 32;
		recv_idle_pct = 61;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_OPEN; i++)
			send_item(OPEN_ROWS[i].req, OPEN_ROWS[i].pos, OPEN_ROWS[i].val,
				OPEN_ROWS[i].typed, OPEN_ROWS[i].exp);

		wait_drained();
		fill = CAPACITY - shadow_list.size();
		for (i = 0; i < fill; i++)
			send_item(REQ_INS_BACK, POS_W'($urandom_range(127, 0)), $urandom(), 1'b0,
				NO_TYPED);
		for (i = 0; i < N_AT_FULL; i++)
			send_item(FULL_ROWS[i].req, FULL_ROWS[i].pos, FULL_ROWS[i].val,
				FULL_ROWS[i].typed, FULL_ROWS[i].exp);

		send_random(RAND_PER_PHASE);
		send_idle_pct = 61;
		recv_idle_pct = 32;
		send_random(RAND_PER_PHASE / 2);
		wait_drained();
		send_random(RAND_PER_PHASE / 2);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(RAND_PER_PHASE);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin : watchdog
		#1ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
